/* hdl/mtdg_pkg.sv */
// shared constants, types and state codes of the despike grid unit
package mtdg_pkg;

   localparam int GRID_COLS_DEF  = 32;
   localparam int GRID_ROWS_DEF  = 32;
   localparam int MAX_HALF_X_DEF = 15;
   localparam int MAX_HALF_Y_DEF = 15;

   localparam int AMP_W = 24;
   localparam int CSR_W = 16;
   localparam logic [AMP_W-1:0] AMP_MAX = {AMP_W{1'b1}};

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_FILTER = 1'b1;

   localparam logic [2:0] CSR_COLS   = 3'd0;
   localparam logic [2:0] CSR_ROWS   = 3'd1;
   localparam logic [2:0] CSR_HALF_X = 3'd2;
   localparam logic [2:0] CSR_HALF_Y = 3'd3;
   localparam logic [2:0] CSR_THRESH = 3'd4;
   localparam logic [2:0] CSR_LEVEL  = 3'd5;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CENTER,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_RANK,
      ST_RANK_LAST,
      ST_MULT,
      ST_DECIDE,
      ST_OUT
   } state_type;

   // memory request from the sequencer to the grid memory
   typedef struct packed {
      logic        we;
      logic [15:0] addr;
      logic [AMP_W-1:0] wamp;
      logic        wuse;
   } mem_req_type;

endpackage

/* hdl/mtdg_grid_mem.sv */
// grid memory: amplitude and use flag per cell, one port, registered read
module mtdg_grid_mem #(
   parameter int CELLS = 1024,
   parameter int AW    = 10
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [AW-1:0]             addr,
   input  logic [mtdg_pkg::AMP_W-1:0] wamp,
   input  logic                      wuse,
   output logic [mtdg_pkg::AMP_W-1:0] ramp,
   output logic                      ruse
);

   logic [mtdg_pkg::AMP_W:0] mem [CELLS];
   logic [mtdg_pkg::AMP_W:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= {wuse, wamp};
      end
      rd_ff <= mem[addr];
   end

   assign ramp = rd_ff[mtdg_pkg::AMP_W-1:0];
   assign ruse = rd_ff[mtdg_pkg::AMP_W];

endmodule

/* hdl/median_threshold_despike_grid_unit.sv */
// despike grid unit top level: sequencer, counting median selection and threshold
// filter: with apply clear or an empty window the ranking is skipped; else a counting scan
// of the window, then a ranking scan per used candidate, unused candidates being skipped
// throughput: one transaction at a time, the next taken once the result is accepted
// reset: a clearing pass over all GRID_COLS*GRID_ROWS cells zeroes the grid, no
// transaction is taken meanwhile; configuration returns to its defaults
module median_threshold_despike_grid_unit #(
   parameter int GRID_COLS  = mtdg_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS  = mtdg_pkg::GRID_ROWS_DEF,
   parameter int MAX_HALF_X = mtdg_pkg::MAX_HALF_X_DEF,
   parameter int MAX_HALF_Y = mtdg_pkg::MAX_HALF_Y_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [4:0]  req_row,
   input  logic [4:0]  req_col,
   input  logic [23:0] req_amplitude,
   input  logic        req_use_flag,
   input  logic        req_apply_flag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_filtered_amplitude,
   output logic [23:0] rsp_median_amplitude,
   output logic        rsp_replaced,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CELLS = GRID_COLS * GRID_ROWS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW    = $clog2(GRID_COLS + 1) + 1;   // signed-safe column width
   localparam int XW    = CW + 9;                      // room for coordinates
   localparam int NW    = AW + 1;                      // window count width
   localparam int AWD   = mtdg_pkg::AMP_W;

   // configuration registers
   logic [5:0]  cols_ff, rows_ff;
   logic [3:0]  hx_ff, hy_ff;
   logic [15:0] thr_ff, lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 6'd32;
         rows_ff <= 6'd32;
         hx_ff   <= 4'd5;
         hy_ff   <= 4'd0;
         thr_ff  <= 16'd768;
         lvl_ff  <= 16'd256;
      end else if (csr_write) begin
         unique case (csr_index)
            mtdg_pkg::CSR_COLS:   cols_ff <= csr_data[5:0];
            mtdg_pkg::CSR_ROWS:   rows_ff <= csr_data[5:0];
            mtdg_pkg::CSR_HALF_X: hx_ff   <= csr_data[3:0];
            mtdg_pkg::CSR_HALF_Y: hy_ff   <= csr_data[3:0];
            mtdg_pkg::CSR_THRESH: thr_ff  <= csr_data;
            mtdg_pkg::CSR_LEVEL:  lvl_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // clamped sizes and half widths, signed coordinates
   logic signed [XW-1:0] cols_c, rows_c, hx_c, hy_c;
   always_comb begin
      cols_c = XW'(cols_ff);
      if (cols_c < 1) cols_c = XW'(1);
      if (cols_c > GRID_COLS) cols_c = XW'(GRID_COLS);
      rows_c = XW'(rows_ff);
      if (rows_c < 1) rows_c = XW'(1);
      if (rows_c > GRID_ROWS) rows_c = XW'(GRID_ROWS);
      hx_c = XW'(hx_ff);
      if (hx_c > MAX_HALF_X) hx_c = XW'(MAX_HALF_X);
      hy_c = XW'(hy_ff);
      if (hy_c > MAX_HALF_Y) hy_c = XW'(MAX_HALF_Y);
   end

   // request coordinates as signed values for the window clamp
   logic signed [XW-1:0] row_s, col_s;
   assign row_s = signed'(XW'(req_row));
   assign col_s = signed'(XW'(req_col));

   // transaction registers
   mtdg_pkg::state_type state_ff, state_in;
   logic        apply_ff;
   logic        inside_r;
   logic signed [XW-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   logic signed [XW-1:0] x_ff, y_ff, x_in, y_in;          // scan pointer
   logic signed [XW-1:0] cx_ff, cy_ff, cx_in, cy_in;      // candidate pointer
   logic [AWD-1:0] amp_ff, cand_ff, med_ff;
   logic [NW-1:0]  n_ff, lt_ff, eq_ff;                     // window count, rank counts
   logic           found_ff, pass_ff;                      // pass 0 counts n
   logic [AW:0]    clr_ff;
   logic [AWD+16-1:0] prod_t_ff, prod_r_ff;
   logic [AWD-1:0] f_ff, m_ff;
   logic           rep_ff;

   logic inside_in;
   assign inside_in = (32'(req_row) < GRID_ROWS) && (32'(req_col) < GRID_COLS);

   // grid memory port
   mtdg_pkg::mem_req_type mreq;
   logic [AWD-1:0] ramp;
   logic           ruse;

   mtdg_grid_mem #(.CELLS(CELLS), .AW(AW)) u_mem (
      .clock (clock),
      .we    (mreq.we),
      .addr  (mreq.addr[AW-1:0]),
      .wamp  (mreq.wamp),
      .wuse  (mreq.wuse),
      .ramp  (ramp),
      .ruse  (ruse)
   );

   function automatic logic [15:0] cell_addr(input logic signed [XW-1:0] y,
                                             input logic signed [XW-1:0] x);
      logic [31:0] a;
      a = 32'(y) * GRID_COLS + 32'(x);
      return a[15:0];
   endfunction

   // scan pointer advances through the window row by row
   logic scan_end;
   assign scan_end = (x_ff == x2_ff) && (y_ff == y2_ff);
   always_comb begin
      x_in = x_ff + XW'(1);
      y_in = y_ff;
      if (x_ff == x2_ff) begin
         x_in = x1_ff;
         y_in = y_ff + XW'(1);
      end
   end
   always_comb begin
      cx_in = cx_ff + XW'(1);
      cy_in = cy_ff;
      if (cx_ff == x2_ff) begin
         cx_in = x1_ff;
         cy_in = cy_ff + XW'(1);
      end
   end
   logic cand_end;
   assign cand_end = (cx_ff == x2_ff) && (cy_ff == y2_ff);

   logic [NW-1:0] k;
   assign k = (n_ff - 1'b1) >> 1;

   // counting pass flags: the first scan counts n, later scans rank the candidate
   // read data in a scan cycle belongs to the cell under the scan pointer
   logic scan_hit;
   assign scan_hit = (state_ff == mtdg_pkg::ST_SCAN);

   logic [NW-1:0] lt_add, eq_add;
   always_comb begin
      lt_add = lt_ff;
      eq_add = eq_ff;
      if (scan_hit && ruse) begin
         if (!pass_ff) lt_add = lt_ff + 1'b1;          // pass 0: lt_ff counts n
         else if (ramp < cand_ff) lt_add = lt_ff + 1'b1;
         else if (ramp == cand_ff) eq_add = eq_ff + 1'b1;
      end
   end

   // candidate holds the median rank
   logic rank_hit;
   assign rank_hit = pass_ff && (lt_add <= k) && (k < lt_add + eq_add);

   // sequencer: next state, ready and memory address
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      mreq      = '0;
      unique case (state_ff)
         mtdg_pkg::ST_CLEAR: begin
            mreq.we   = 1'b1;
            mreq.addr = 16'(clr_ff);
            if (clr_ff == (AW+1)'(CELLS - 1)) state_in = mtdg_pkg::ST_IDLE;
         end
         mtdg_pkg::ST_IDLE: begin
            req_ready = !rsp_valid;
            mreq.addr = cell_addr(row_s, col_s);
            if (req_valid && !rsp_valid) begin
               if (req_opcode == mtdg_pkg::OP_WRITE) begin
                  mreq.we   = inside_in;
                  mreq.wamp = req_amplitude;
                  mreq.wuse = req_use_flag;
               end else begin
                  state_in = mtdg_pkg::ST_CENTER;
               end
            end
         end
         mtdg_pkg::ST_CENTER: begin
            // center amplitude arrives; begin counting pass unless apply is clear or the window is empty
            mreq.addr = cell_addr(y1_ff, x1_ff);
            if (!apply_ff || x1_ff > x2_ff || y1_ff > y2_ff) state_in = mtdg_pkg::ST_MULT;
            else state_in = mtdg_pkg::ST_SCAN;
         end
         mtdg_pkg::ST_SCAN: begin
            mreq.addr = cell_addr(y_in, x_in);
            if (scan_end) state_in = mtdg_pkg::ST_SCAN_LAST;
         end
         mtdg_pkg::ST_SCAN_LAST: begin
            // window done; read the candidate to rank next
            if (pass_ff && !rank_hit) mreq.addr = cell_addr(cy_in, cx_in);
            else mreq.addr = cell_addr(cy_ff, cx_ff);
            if (found_ff) state_in = mtdg_pkg::ST_MULT;
            else state_in = mtdg_pkg::ST_RANK;
         end
         mtdg_pkg::ST_RANK: begin
            // candidate value arrives
            mreq.addr = cell_addr(y1_ff, x1_ff);
            if (!ruse) begin
               if (cand_end) state_in = mtdg_pkg::ST_MULT;
               else state_in = mtdg_pkg::ST_RANK_LAST;
            end else begin
               state_in = mtdg_pkg::ST_SCAN;
            end
         end
         mtdg_pkg::ST_RANK_LAST: begin
            // skip an unused candidate: read the next one
            mreq.addr = cell_addr(cy_ff, cx_ff);
            state_in  = mtdg_pkg::ST_RANK;
         end
         mtdg_pkg::ST_MULT:   state_in = mtdg_pkg::ST_DECIDE;
         mtdg_pkg::ST_DECIDE: state_in = mtdg_pkg::ST_OUT;
         mtdg_pkg::ST_OUT:    state_in = mtdg_pkg::ST_IDLE;
         default:             state_in = mtdg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mtdg_pkg::ST_CLEAR;
         clr_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == mtdg_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == mtdg_pkg::ST_OUT) rsp_valid <= 1'b1;
         else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         mtdg_pkg::ST_IDLE: begin
            apply_ff <= req_apply_flag;
            inside_r <= inside_in;
            x1_ff <= (col_s - hx_c < 0) ? '0 : col_s - hx_c;
            x2_ff <= (col_s + hx_c > cols_c - XW'(1)) ? cols_c - XW'(1) : col_s + hx_c;
            y1_ff <= (row_s - hy_c < 0) ? '0 : row_s - hy_c;
            y2_ff <= (row_s + hy_c > rows_c - XW'(1)) ? rows_c - XW'(1) : row_s + hy_c;
            med_ff   <= '0;
            found_ff <= 1'b0;
            pass_ff  <= 1'b0;
            lt_ff    <= '0;
            eq_ff    <= '0;
         end
         mtdg_pkg::ST_CENTER: begin
            amp_ff <= inside_r ? ramp : '0;
            x_ff   <= x1_ff;
            y_ff   <= y1_ff;
            cx_ff  <= x1_ff;
            cy_ff  <= y1_ff;
         end
         mtdg_pkg::ST_SCAN: begin
            lt_ff <= lt_add;
            eq_ff <= eq_add;
            x_ff  <= x_in;
            y_ff  <= y_in;
         end
         mtdg_pkg::ST_SCAN_LAST: begin
            x_ff <= x1_ff;
            y_ff <= y1_ff;
            if (!pass_ff) begin
               n_ff     <= lt_add;
               found_ff <= (lt_add == '0);
            end else if (rank_hit) begin
               med_ff   <= cand_ff;
               found_ff <= 1'b1;
            end else begin
               cx_ff <= cx_in;
               cy_ff <= cy_in;
            end
            pass_ff <= 1'b1;
            lt_ff   <= '0;
            eq_ff   <= '0;
         end
         mtdg_pkg::ST_RANK: begin
            cand_ff <= ramp;
            if (!ruse) begin
               cx_ff <= cx_in;
               cy_ff <= cy_in;
            end
         end
         mtdg_pkg::ST_MULT: begin
            prod_t_ff <= (AWD+16)'(thr_ff) * (AWD+16)'(med_ff);
            prod_r_ff <= (AWD+16)'(lvl_ff) * (AWD+16)'(med_ff) + (AWD+16)'(128);
         end
         mtdg_pkg::ST_DECIDE: begin
            m_ff   <= apply_ff ? med_ff : '0;
            f_ff   <= amp_ff;
            rep_ff <= 1'b0;
            if (apply_ff && ({8'd0, amp_ff, 8'd0} > prod_t_ff)) begin
               rep_ff <= 1'b1;
               f_ff   <= (prod_r_ff[AWD+15:AWD+8] != '0) ? mtdg_pkg::AMP_MAX
                                                       : prod_r_ff[AWD+7:8];
            end
         end
         default: ;
      endcase
   end

   assign rsp_filtered_amplitude = f_ff;
   assign rsp_median_amplitude   = m_ff;
   assign rsp_replaced           = rep_ff;

endmodule
